FILE: design/spn_block_cipher_16bit_assert.svh
// assertion macros shared by the spn cipher rtl
// no dependencies; included by files that carry assertions
`ifndef SPN_BLOCK_CIPHER_16BIT_ASSERT_SVH
`define SPN_BLOCK_CIPHER_16BIT_ASSERT_SVH

// checked on every rising clock edge outside reset
`define SPN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every rising clock edge, reset included
`define SPN_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: design/spn_pkg.sv
// shared types, s-box tables and permutation for the 16-bit spn cipher
// no dependencies; used by spn_round_cell and spn_block_cipher_16bit
package spn_pkg;

  localparam int unsigned BlockW = 16;
  localparam int unsigned KeyW   = 32;
  localparam int unsigned NibW   = 4;
  localparam int unsigned NumCells = 4;

  typedef enum logic {
    CMD_ENCRYPT = 1'b0,
    CMD_DECRYPT = 1'b1
  } cmd_e;

  // one request as it travels down the cell chain
  typedef struct packed {
    cmd_e              cmd;
    logic [KeyW-1:0]   key;
    logic [BlockW-1:0] data;
  } spn_item_t;

  localparam logic [NibW-1:0] SBOX_FWD [16] = '{
    4'hE, 4'h4, 4'hD, 4'h1, 4'h2, 4'hF, 4'hB, 4'h8,
    4'h3, 4'hA, 4'h6, 4'hC, 4'h5, 4'h9, 4'h0, 4'h7
  };

  localparam logic [NibW-1:0] SBOX_INV [16] = '{
    4'hE, 4'h3, 4'h4, 4'h8, 4'h1, 4'hC, 4'hA, 4'hF,
    4'h7, 4'hD, 4'h9, 4'h6, 4'hB, 4'h2, 4'h0, 4'h5
  };

  // four parallel forward s-box lookups
  function automatic logic [BlockW-1:0] subst_fwd(input logic [BlockW-1:0] x);
    logic [BlockW-1:0] y;
    y = '0;
    for (int n = 0; n < 4; n++) begin
      y[n*NibW +: NibW] = SBOX_FWD[x[n*NibW +: NibW]];
    end
    return y;
  endfunction

  // four parallel inverse s-box lookups
  function automatic logic [BlockW-1:0] subst_inv(input logic [BlockW-1:0] x);
    logic [BlockW-1:0] y;
    y = '0;
    for (int n = 0; n < 4; n++) begin
      y[n*NibW +: NibW] = SBOX_INV[x[n*NibW +: NibW]];
    end
    return y;
  endfunction

  // 4x4 bit transpose, msb-first positions; its own inverse
  function automatic logic [BlockW-1:0] permute(input logic [BlockW-1:0] x);
    logic [BlockW-1:0] y;
    y = '0;
    for (int p = 0; p < 16; p++) begin
      y[15 - ((p % 4) * 4 + (p / 4))] = x[15 - p];
    end
    return y;
  endfunction

endpackage

FILE: design/spn_round_cell.sv
// one round cell of the spn cipher chain, with its own pipeline register
// depends on spn_pkg and spn_block_cipher_16bit_assert.svh
`include "spn_block_cipher_16bit_assert.svh"

module spn_round_cell #(
  parameter int unsigned CellIdx = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  spn_pkg::spn_item_t item_i,
  output logic              valid_o,
  input  logic              ready_i,
  output spn_pkg::spn_item_t item_o
);

  // key windows used by this cell (msb index of each 16-bit round key)
  localparam int unsigned EncKeyHi = 31 - 4 * CellIdx;
  localparam int unsigned DecKeyHi = 19 + 4 * CellIdx;
  localparam bit FirstCell = (CellIdx == 0);
  localparam bit LastCell  = (CellIdx == spn_pkg::NumCells - 1);

  logic [spn_pkg::BlockW-1:0] enc_sub, enc_out, dec_pre, dec_out, round_out;
  logic                       valid_q;
  spn_pkg::spn_item_t         item_q, item_d;

  // encrypt: key mix, s-boxes, then transpose or final key whitening
  assign enc_sub = spn_pkg::subst_fwd(item_i.data ^ item_i.key[EncKeyHi -: spn_pkg::BlockW]);
  assign enc_out = LastCell ? (enc_sub ^ item_i.key[spn_pkg::BlockW-1:0])
                            : spn_pkg::permute(enc_sub);

  // decrypt: initial whitening or transpose, inverse s-boxes, key mix
  assign dec_pre = FirstCell ? (item_i.data ^ item_i.key[spn_pkg::BlockW-1:0])
                             : spn_pkg::permute(item_i.data);
  assign dec_out = spn_pkg::subst_inv(dec_pre) ^ item_i.key[DecKeyHi -: spn_pkg::BlockW];

  always_comb begin
    unique case (item_i.cmd)
      spn_pkg::CMD_ENCRYPT: round_out = enc_out;
      spn_pkg::CMD_DECRYPT: round_out = dec_out;
      default:              round_out = enc_out;
    endcase
    item_d      = item_i;
    item_d.data = round_out;
  end

  // stage takes a new request when empty or when its result moves on
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

  `SPN_ASSERT(a_load_fills, (valid_i && ready_o) |=> valid_q, "accepted request not held")
  `SPN_ASSERT(a_stall_keeps, (valid_q && !ready_i) |=> valid_q, "stalled request dropped")
  `SPN_ASSERT(a_key_travels, (valid_i && ready_o) |=> (item_q.key == $past(item_i.key)),
              "round key source corrupted")
  `SPN_ASSERT_ALWAYS(a_empty_ready, !valid_q |-> ready_o, "empty cell refuses request")

endmodule

FILE: design/spn_block_cipher_16bit.sv
// Textbook 16-bit SPN cipher (32-bit key, five round keys), encrypt or decrypt per
// request. Four round cells form a pipeline: a request enters every cycle while
// the chain is not stalled, and its result appears on the output register of the
// last cell. Full rate holds under downstream stalls as long as each cell drains
// as it fills; the ready path runs back combinationally through the four cells.
// depends on spn_pkg and spn_round_cell
module spn_block_cipher_16bit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [31:0] cipher_key_i,
  input  logic [15:0] data_block_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] result_block_o
);

  localparam int unsigned N = spn_pkg::NumCells;

  logic               valid_s [N+1];
  logic               ready_s [N+1];
  spn_pkg::spn_item_t item_s  [N+1];

  // chain head
  assign valid_s[0]     = in_valid_i;
  assign in_ready_o     = ready_s[0];
  assign item_s[0].cmd  = spn_pkg::cmd_e'(cmd_i);
  assign item_s[0].key  = cipher_key_i;
  assign item_s[0].data = data_block_i;

  // row of round cells
  for (genvar i = 0; i < N; i++) begin : g_cell
    spn_round_cell #(
      .CellIdx(i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(valid_s[i]),
      .ready_o(ready_s[i]),
      .item_i (item_s[i]),
      .valid_o(valid_s[i+1]),
      .ready_i(ready_s[i+1]),
      .item_o (item_s[i+1])
    );
  end

  // chain tail
  assign out_valid_o    = valid_s[N];
  assign ready_s[N]     = out_ready_i;
  assign result_block_o = item_s[N].data;

endmodule
